// File: rtl/lens_distortion_mapper_assert.svh
// assertion macros for the lens distortion mapper
`ifndef LENS_DISTORTION_MAPPER_ASSERT_SVH
`define LENS_DISTORTION_MAPPER_ASSERT_SVH

// same-cycle implication
`define LDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lens distortion mapper check failed");

// next-cycle implication
`define LDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lens distortion mapper check failed");

`endif

// File: rtl/ldm_pkg.sv
// shared types, constants and fixed-point helpers for the lens distortion mapper
package ldm_pkg;

  localparam int FRAC     = 28;
  localparam int QW       = 32;
  localparam int DIV_LAT  = QW + 2;
  localparam int ITER_LAT = 6 + DIV_LAT;
  localparam int POST_LAT = 4;

  localparam logic OP_UNDISTORT = 1'b0;
  localparam logic OP_DISTORT   = 1'b1;

  localparam logic signed [63:0] ONE_Q   = 64'sd268435456;
  localparam logic signed [63:0] ROUND_Q = 64'sd134217728;
  localparam logic signed [63:0] Q_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN   = -64'sd2147483648;
  localparam logic signed [63:0] PIX_MAX = 64'sd8388607;
  localparam logic signed [63:0] PIX_MIN = -64'sd8388608;

  localparam logic [23:0] FOCAL_RESET = 24'd256;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_K1,
    REG_K2,
    REG_P1,
    REG_P2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               f;
  } qres_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  typedef struct packed {
    logic               valid;
    logic               op;
    logic               held;
    logic               bad;
    logic               fault;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic signed [31:0] radial;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } item_t;

  function automatic qres_t sat_q(input logic signed [63:0] v);
    qres_t r;
    if (v > Q_MAX) begin
      r.v = 32'sh7fffffff;
      r.f = 1'b1;
    end else if (v < Q_MIN) begin
      r.v = 32'sh80000000;
      r.f = 1'b1;
    end else begin
      r.v = v[31:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  function automatic qres_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + ROUND_Q;
    return sat_q(p >>> FRAC);
  endfunction

endpackage

// File: rtl/ldm_div.sv
// pipelined signed divider, one quotient bit per stage, saturating 32 bit quotient
module ldm_div #(
  parameter int NW = 53,
  parameter int DW = 24
) (
  input  logic                  clk,
  input  logic [NW-1:0]         num_mag,
  input  logic                  num_neg,
  input  logic [DW-1:0]         den,
  output logic signed [31:0]    quot,
  output logic                  ovf
);
  import ldm_pkg::*;

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] bits [QW+1];
  logic [DW-1:0] dens [QW+1];
  logic          negs [QW+1];
  logic          bigs [QW+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic [QW-1:0] q;
  logic          over;
  logic [QW-1:0] q_fin;

  function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                            input logic [DW-1:0] dv);
    logic [DW:0] t;
    logic [DW:0] d;
    t = {r, b};
    d = t - {1'b0, dv};
    if (t >= {1'b0, dv}) return {1'b1, d[DW-1:0]};
    return {1'b0, t[DW-1:0]};
  endfunction

  always_comb begin
    hi_ext  = CW'(num_mag[NW-1:QW]);
    den_ext = CW'(den);
  end

  always_ff @(posedge clk) begin
    logic [DW:0] s;
    rem[0]  <= hi_ext[DW-1:0];
    bits[0] <= num_mag[QW-1:0];
    dens[0] <= den;
    negs[0] <= num_neg;
    bigs[0] <= (hi_ext >= den_ext);
    for (int k = 1; k <= QW; k++) begin
      s = div_step(rem[k-1], bits[k-1][QW-1], dens[k-1]);
      rem[k]  <= s[DW-1:0];
      bits[k] <= {bits[k-1][QW-2:0], s[DW]};
      dens[k] <= dens[k-1];
      negs[k] <= negs[k-1];
      bigs[k] <= bigs[k-1];
    end
  end

  always_comb begin
    q = bits[QW];
    if (negs[QW]) begin
      over  = bigs[QW] || (q[QW-1] && (|q[QW-2:0]));
      q_fin = over ? {1'b1, {(QW-1){1'b0}}} : (~q + 1'b1);
    end else begin
      over  = bigs[QW] || q[QW-1];
      q_fin = over ? {1'b0, {(QW-1){1'b1}}} : q;
    end
  end

  always_ff @(posedge clk) begin
    quot <= q_fin;
    ovf  <= over;
  end

endmodule

// File: rtl/ldm_iter.sv
// one distortion model evaluation plus one inversion step
module ldm_iter (
  input  logic          clk,
  input  logic          rst,
  input  ldm_pkg::coef_t coef,
  input  ldm_pkg::item_t d_in,
  output ldm_pkg::item_t d_out
);
  import ldm_pkg::*;

  item_t i1, i2, i3, i4, i5, nxt, fin;
  item_t dl [DIV_LAT];

  qres_t xx, yy, xy;
  qres_t r2, ax, ay;
  logic signed [31:0] r2_r, ax_r, ay_r, xy_r;
  logic f2;
  qres_t r4, ka, pb, pc, pd, pe;
  logic f3;
  qres_t kb;
  logic signed [31:0] a4, b4, c4, d4, e4, kb4;
  logic f4;
  qres_t rad, mdx, mdy;
  logic mf;

  logic act;
  logic signed [32:0] nx, ny;
  logic [32:0] mx, my;
  logic [31:0] den;
  logic signed [31:0] qx, qy;
  logic ox, oy;
  logic pa;

  // stage 1: squares and cross product
  always_ff @(posedge clk) begin
    i1 <= d_in;
    xx <= qmul(d_in.xn, d_in.xn);
    yy <= qmul(d_in.yn, d_in.yn);
    xy <= qmul(d_in.xn, d_in.yn);
    if (rst) i1.valid <= 1'b0;
  end

  // stage 2: radius and tangential sums
  always_comb begin
    r2 = sat_q(64'(xx.v) + 64'(yy.v));
    ax = sat_q(64'(r2.v) + (64'(xx.v) <<< 1));
    ay = sat_q(64'(r2.v) + (64'(yy.v) <<< 1));
  end

  always_ff @(posedge clk) begin
    i2   <= i1;
    r2_r <= r2.v;
    ax_r <= ax.v;
    ay_r <= ay.v;
    xy_r <= xy.v;
    f2   <= xx.f | yy.f | xy.f | r2.f | ax.f | ay.f;
    if (rst) i2.valid <= 1'b0;
  end

  // stage 3: coefficient products
  always_ff @(posedge clk) begin
    i3 <= i2;
    r4 <= qmul(r2_r, r2_r);
    ka <= qmul(coef.k1, r2_r);
    pb <= qmul(coef.p1, xy_r);
    pc <= qmul(coef.p2, ax_r);
    pd <= qmul(coef.p1, ay_r);
    pe <= qmul(coef.p2, xy_r);
    f3 <= f2;
    if (rst) i3.valid <= 1'b0;
  end

  // stage 4: fourth-order radial term
  always_comb kb = qmul(coef.k2, r4.v);

  always_ff @(posedge clk) begin
    i4  <= i3;
    a4  <= ka.v;
    b4  <= pb.v;
    c4  <= pc.v;
    d4  <= pd.v;
    e4  <= pe.v;
    kb4 <= kb.v;
    f4  <= f3 | r4.f | ka.f | pb.f | pc.f | pd.f | pe.f | kb.f;
    if (rst) i4.valid <= 1'b0;
  end

  // stage 5: radial factor and tangential offsets
  always_comb begin
    rad = sat_q(ONE_Q + 64'(a4) + 64'(kb4));
    mdx = sat_q((64'(b4) <<< 1) + 64'(c4));
    mdy = sat_q(64'(d4) + (64'(e4) <<< 1));
    mf  = f4 | rad.f | mdx.f | mdy.f;
    nxt = i4;
    if (i4.op == OP_DISTORT) begin
      if (!i4.held) begin
        nxt.radial = rad.v;
        nxt.dx     = mdx.v;
        nxt.dy     = mdy.v;
        nxt.held   = 1'b1;
        nxt.fault  = i4.fault | mf | (rad.v <= 32'sd0);
      end
    end else if (!i4.bad) begin
      nxt.radial = rad.v;
      nxt.dx     = mdx.v;
      nxt.dy     = mdy.v;
      nxt.fault  = i4.fault | mf;
      if (rad.v <= 32'sd0) begin
        nxt.bad   = 1'b1;
        nxt.fault = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    i5 <= nxt;
    if (rst) i5.valid <= 1'b0;
  end

  // inversion step: (x0 - dx) / radial
  always_comb begin
    act = (i5.op == OP_UNDISTORT) && !i5.bad;
    nx  = {i5.x0[31], i5.x0} - {i5.dx[31], i5.dx};
    ny  = {i5.y0[31], i5.y0} - {i5.dy[31], i5.dy};
    mx  = nx[32] ? 33'(-nx) : 33'(nx);
    my  = ny[32] ? 33'(-ny) : 33'(ny);
    den = act ? i5.radial : 32'd1;
  end

  ldm_div #(.NW(33 + FRAC), .DW(32)) u_div_x (
    .clk(clk), .num_mag({mx, {FRAC{1'b0}}}), .num_neg(nx[32]), .den(den),
    .quot(qx), .ovf(ox)
  );

  ldm_div #(.NW(33 + FRAC), .DW(32)) u_div_y (
    .clk(clk), .num_mag({my, {FRAC{1'b0}}}), .num_neg(ny[32]), .den(den),
    .quot(qy), .ovf(oy)
  );

  always_ff @(posedge clk) begin
    dl[0] <= i5;
    for (int k = 1; k < DIV_LAT; k++) dl[k] <= dl[k-1];
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) dl[k].valid <= 1'b0;
    end
  end

  always_comb begin
    pa  = (dl[DIV_LAT-1].op == OP_UNDISTORT) && !dl[DIV_LAT-1].bad;
    fin = dl[DIV_LAT-1];
    if (pa) begin
      fin.xn    = qx;
      fin.yn    = qy;
      fin.fault = dl[DIV_LAT-1].fault | ox | oy;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= fin;
    if (rst) d_out.valid <= 1'b0;
  end

endmodule

// File: rtl/lens_distortion_mapper.sv
// top level of the lens distortion mapper
// throughput: one request per cycle outside reset; the divider and multiplier chains are fully pipelined
// busy is high only during reset; results appear on done for one cycle and cannot be stalled
// reset clears the valid bits and loads the register defaults, no clearing pass
`include "lens_distortion_mapper_assert.svh"

module lens_distortion_mapper #(
  parameter int ITERATIONS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [23:0] in_x,
  input  logic signed [23:0] in_y,
  output logic               done,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic               status,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data
);
  import ldm_pkg::*;

  localparam int LAT = 2 + DIV_LAT + ITERATIONS * ITER_LAT + POST_LAT;

  typedef struct packed {
    logic signed [23:0] v;
    logic               f;
  } pres_t;

  function automatic pres_t to_pix(input logic signed [63:0] prod,
                                   input logic signed [23:0] c);
    logic signed [63:0] w;
    pres_t r;
    w = ((prod + ROUND_Q) >>> FRAC) + 64'(c);
    if (w > PIX_MAX) begin
      r.v = 24'sh7fffff;
      r.f = 1'b1;
    end else if (w < PIX_MIN) begin
      r.v = 24'sh800000;
      r.f = 1'b1;
    end else begin
      r.v = w[23:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  logic [23:0]        focal_x, focal_y;
  logic signed [23:0] center_x, center_y;
  coef_t              coef;
  logic [23:0]        fx_eff, fy_eff;

  item_t e_next, e, n_next, n_item, f1, f2_next, f2, f3;
  item_t nd [DIV_LAT];
  item_t st [ITERATIONS+1];

  logic signed [24:0] sx, sy;
  logic [24:0]        mx, my;
  logic signed [31:0] qx, qy;
  logic               ox, oy;

  qres_t tx, ty, ux, uy;
  logic signed [63:0] px_prod, py_prod;
  pres_t cx, cy;

  assign busy = rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_RESET;
      focal_y  <= FOCAL_RESET;
      center_x <= '0;
      center_y <= '0;
      coef     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_FOCAL_X:  focal_x  <= wr_data[23:0];
        REG_FOCAL_Y:  focal_y  <= wr_data[23:0];
        REG_CENTER_X: center_x <= wr_data[23:0];
        REG_CENTER_Y: center_y <= wr_data[23:0];
        REG_K1:       coef.k1  <= wr_data;
        REG_K2:       coef.k2  <= wr_data;
        REG_P1:       coef.p1  <= wr_data;
        REG_P2:       coef.p2  <= wr_data;
      endcase
    end
  end

  always_comb begin
    fx_eff = (focal_x == 24'd0) ? 24'd1 : focal_x;
    fy_eff = (focal_y == 24'd0) ? 24'd1 : focal_y;
  end

  // entry register
  always_comb begin
    e_next       = '0;
    e_next.valid = start && !busy;
    e_next.op    = opcode;
    e_next.px    = in_x;
    e_next.py    = in_y;
  end

  always_ff @(posedge clk) begin
    e <= e_next;
    if (rst) e.valid <= 1'b0;
  end

  // normalize: (p - c) / focal
  always_comb begin
    sx = {e.px[23], e.px} - {center_x[23], center_x};
    sy = {e.py[23], e.py} - {center_y[23], center_y};
    mx = sx[24] ? 25'(-sx) : 25'(sx);
    my = sy[24] ? 25'(-sy) : 25'(sy);
  end

  ldm_div #(.NW(25 + FRAC), .DW(24)) u_norm_x (
    .clk(clk), .num_mag({mx, {FRAC{1'b0}}}), .num_neg(sx[24]), .den(fx_eff),
    .quot(qx), .ovf(ox)
  );

  ldm_div #(.NW(25 + FRAC), .DW(24)) u_norm_y (
    .clk(clk), .num_mag({my, {FRAC{1'b0}}}), .num_neg(sy[24]), .den(fy_eff),
    .quot(qy), .ovf(oy)
  );

  always_ff @(posedge clk) begin
    nd[0] <= e;
    for (int k = 1; k < DIV_LAT; k++) nd[k] <= nd[k-1];
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) nd[k].valid <= 1'b0;
    end
  end

  always_comb begin
    n_next       = nd[DIV_LAT-1];
    n_next.x0    = qx;
    n_next.y0    = qy;
    n_next.xn    = qx;
    n_next.yn    = qy;
    n_next.fault = ox | oy;
  end

  always_ff @(posedge clk) begin
    n_item <= n_next;
    if (rst) n_item.valid <= 1'b0;
  end

  assign st[0] = n_item;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
    ldm_iter u_iter (
      .clk(clk), .rst(rst), .coef(coef), .d_in(st[g]), .d_out(st[g+1])
    );
  end

  // distort: scale by radial factor
  always_ff @(posedge clk) begin
    f1 <= st[ITERATIONS];
    tx <= qmul(st[ITERATIONS].x0, st[ITERATIONS].radial);
    ty <= qmul(st[ITERATIONS].y0, st[ITERATIONS].radial);
    if (rst) f1.valid <= 1'b0;
  end

  // distort: add tangential offset
  always_comb begin
    ux      = sat_q(64'(tx.v) + 64'(f1.dx));
    uy      = sat_q(64'(ty.v) + 64'(f1.dy));
    f2_next = f1;
    if (f1.op == OP_DISTORT) begin
      f2_next.xn    = ux.v;
      f2_next.yn    = uy.v;
      f2_next.fault = f1.fault | tx.f | ty.f | ux.f | uy.f;
    end
  end

  always_ff @(posedge clk) begin
    f2 <= f2_next;
    if (rst) f2.valid <= 1'b0;
  end

  // denormalize: multiply by focal length
  always_ff @(posedge clk) begin
    f3      <= f2;
    px_prod <= 64'(f2.xn) * $signed({40'd0, fx_eff});
    py_prod <= 64'(f2.yn) * $signed({40'd0, fy_eff});
    if (rst) f3.valid <= 1'b0;
  end

  // round, add center, clamp
  always_comb begin
    cx = to_pix(px_prod, center_x);
    cy = to_pix(py_prod, center_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f3.valid;
    end
    if (f3.bad) begin
      out_x  <= f3.px;
      out_y  <= f3.py;
      status <= 1'b1;
    end else begin
      out_x  <= cx.v;
      out_y  <= cy.v;
      status <= f3.fault | cx.f | cy.f;
    end
  end

  `LDM_ASSERT_IMP(a_latency, 1'b1, done == $past(start && !busy, LAT))
  `LDM_ASSERT_IMP(a_distort_clean, st[ITERATIONS].valid && st[ITERATIONS].op == OP_DISTORT, st[ITERATIONS].held && !st[ITERATIONS].bad)
  `LDM_ASSERT_NXT(a_bad_status, f3.valid && f3.bad, done && status)

endmodule
